FILE: rtl/shtf_pkg.sv
package shtf_pkg;

   typedef logic [63:0] word_type;
   typedef logic [7:0]  lane_mask_type;
   typedef logic [1:0]  csr_index_type;

   // Configuration register indexes
   localparam csr_index_type CSR_HASH_SEED      = 2'd0;
   localparam csr_index_type CSR_KEEP_THRESHOLD = 2'd1;

   localparam word_type SEED_RESET      = 64'h0000_0000_0000_0000;
   localparam word_type THRESHOLD_RESET = 64'hffff_ffff_ffff_ffff;

   // Finalizer constants
   localparam word_type    MIX_MUL_A = 64'hff51_afd7_ed55_8ccd;
   localparam word_type    MIX_MUL_B = 64'hc4ce_b9fe_1a85_ec53;
   localparam int unsigned MIX_SHIFT = 33;

   localparam int unsigned LANE_FIELDS = 8;
   localparam int unsigned PIPE_STAGES = 6;

   function automatic word_type xor_shift(input word_type x);
      xor_shift = x ^ (x >> MIX_SHIFT);
   endfunction

endpackage

FILE: rtl/seeded_hash_threshold_filter_x8.sv
// Eight-lane seeded hash filter. Each beat on the req_ channel carries eight
// 64-bit values and a lane-valid mask; every value is XORed with the hash_seed
// register and run through the 64-bit finalizer (xor-shift 33, multiply,
// xor-shift 33, multiply, xor-shift 33). The rsp_ beat returns all eight
// fingerprints, including those of invalid lanes, and kept_mask, which flags
// the valid lanes whose fingerprint is at most keep_threshold (unsigned).
// Lanes at or above LANES read as zero fingerprint and are never kept.
// A new beat is taken every cycle unless rsp_ready back-pressure stalls the
// pipeline; rsp_valid rises when the beat reaches the last stage.
// The six stages are: seed and first xor-shift, the 32-bit partial
// products of the first multiply, their sum and second xor-shift, the partial
// products of the second multiply, their sum and final xor-shift, and the
// threshold compare. Each stage holds only while its successor is full and
// stalled, so bubbles are squeezed out under back-pressure. Write the csr_
// registers only while the pipeline is empty.
module seeded_hash_threshold_filter_x8 #(
   parameter int unsigned LANES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_we,
   input  shtf_pkg::csr_index_type  csr_index,
   input  shtf_pkg::word_type       csr_wdata,
   // request
   input  logic                     req_valid,
   output logic                     req_ready,
   input  shtf_pkg::word_type       req_value_0,
   input  shtf_pkg::word_type       req_value_1,
   input  shtf_pkg::word_type       req_value_2,
   input  shtf_pkg::word_type       req_value_3,
   input  shtf_pkg::word_type       req_value_4,
   input  shtf_pkg::word_type       req_value_5,
   input  shtf_pkg::word_type       req_value_6,
   input  shtf_pkg::word_type       req_value_7,
   input  shtf_pkg::lane_mask_type  req_lane_valid,
   // response
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output shtf_pkg::word_type       rsp_fingerprint_0,
   output shtf_pkg::word_type       rsp_fingerprint_1,
   output shtf_pkg::word_type       rsp_fingerprint_2,
   output shtf_pkg::word_type       rsp_fingerprint_3,
   output shtf_pkg::word_type       rsp_fingerprint_4,
   output shtf_pkg::word_type       rsp_fingerprint_5,
   output shtf_pkg::word_type       rsp_fingerprint_6,
   output shtf_pkg::word_type       rsp_fingerprint_7,
   output shtf_pkg::lane_mask_type  rsp_kept_mask
);
   import shtf_pkg::*;

   // Stages that carry the lane mask before the compare stage
   localparam int unsigned MASK_STAGES = PIPE_STAGES - 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   word_type seed_ff, seed_in;
   word_type thresh_ff, thresh_in;

   always_comb begin
      seed_in   = seed_ff;
      thresh_in = thresh_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HASH_SEED:      seed_in   = csr_wdata;
            CSR_KEEP_THRESHOLD: thresh_in = csr_wdata;
            default: ;          // unknown index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= SEED_RESET;
         thresh_ff <= THRESHOLD_RESET;
      end else begin
         seed_ff   <= seed_in;
         thresh_ff <= thresh_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: a stage may load when it is empty or when the
   // stage after it loads this cycle. The last stage drains on rsp_ready.
   // ------------------------------------------------------------------
   logic [PIPE_STAGES-1:0] vld_ff, vld_in;
   logic [PIPE_STAGES:0]   stage_ready;

   always_comb begin
      stage_ready[PIPE_STAGES] = rsp_ready;
      for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
         stage_ready[k] = !vld_ff[k] || stage_ready[k+1];
      end
   end

   always_comb begin
      vld_in[0] = stage_ready[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < PIPE_STAGES; k++) begin
         if (!stage_ready[k]) begin
            vld_in[k] = vld_ff[k];             // hold
         end else begin
            vld_in[k] = vld_ff[k-1];           // advance
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = vld_ff[PIPE_STAGES-1];

   // Lane mask travels alongside the data up to the compare stage
   lane_mask_type mask_ff [MASK_STAGES];

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         mask_ff[0] <= req_lane_valid;
      end
      for (int k = 1; k < MASK_STAGES; k++) begin
         if (stage_ready[k]) begin
            mask_ff[k] <= mask_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Lane datapath. Each 64x64 multiply keeps only the low 64 bits:
   //   lo*lo (full 64 bits) + ((hi*lo + lo*hi) mod 2^32) << 32
   // The three products of 32-bit halves are registered, then summed next stage.
   // ------------------------------------------------------------------
   word_type req_value [LANE_FIELDS];

   assign req_value[0] = req_value_0;
   assign req_value[1] = req_value_1;
   assign req_value[2] = req_value_2;
   assign req_value[3] = req_value_3;
   assign req_value[4] = req_value_4;
   assign req_value[5] = req_value_5;
   assign req_value[6] = req_value_6;
   assign req_value[7] = req_value_7;

   word_type    x0_ff   [LANES], x0_in   [LANES];
   word_type    pa_ll_ff[LANES], pa_ll_in[LANES];
   logic [31:0] pa_hl_ff[LANES], pa_hl_in[LANES];
   logic [31:0] pa_lh_ff[LANES], pa_lh_in[LANES];
   word_type    x2_ff   [LANES], x2_in   [LANES];
   word_type    pb_ll_ff[LANES], pb_ll_in[LANES];
   logic [31:0] pb_hl_ff[LANES], pb_hl_in[LANES];
   logic [31:0] pb_lh_ff[LANES], pb_lh_in[LANES];
   word_type    fp4_ff  [LANES], fp4_in  [LANES];
   word_type    fp5_ff  [LANES];

   lane_mask_type kept_ff, kept_in;
   word_type      fp_out [LANE_FIELDS];

   for (genvar l = 0; l < LANE_FIELDS; l++) begin : g_lane
      if (l < LANES) begin : g_live
         // stage 0: seed, first xor-shift
         assign x0_in[l] = xor_shift(req_value[l] ^ seed_ff);

         // stage 1: partial products of the first multiply
         assign pa_ll_in[l] = 64'(x0_ff[l][31:0]) * 64'(MIX_MUL_A[31:0]);
         assign pa_hl_in[l] = 32'(x0_ff[l][63:32] * MIX_MUL_A[31:0]);
         assign pa_lh_in[l] = 32'(x0_ff[l][31:0] * MIX_MUL_A[63:32]);

         // stage 2: combine, second xor-shift
         assign x2_in[l] = xor_shift(pa_ll_ff[l] +
                                     {pa_hl_ff[l] + pa_lh_ff[l], 32'h0});

         // stage 3: partial products of the second multiply
         assign pb_ll_in[l] = 64'(x2_ff[l][31:0]) * 64'(MIX_MUL_B[31:0]);
         assign pb_hl_in[l] = 32'(x2_ff[l][63:32] * MIX_MUL_B[31:0]);
         assign pb_lh_in[l] = 32'(x2_ff[l][31:0] * MIX_MUL_B[63:32]);

         // stage 4: combine, final xor-shift
         assign fp4_in[l] = xor_shift(pb_ll_ff[l] +
                                      {pb_hl_ff[l] + pb_lh_ff[l], 32'h0});

         // stage 5: threshold compare on valid lanes only
         assign kept_in[l] = mask_ff[MASK_STAGES-1][l] && (fp4_ff[l] <= thresh_ff);

         always_ff @(posedge clock) begin
            if (stage_ready[0]) begin
               x0_ff[l] <= x0_in[l];
            end
            if (stage_ready[1]) begin
               pa_ll_ff[l] <= pa_ll_in[l];
               pa_hl_ff[l] <= pa_hl_in[l];
               pa_lh_ff[l] <= pa_lh_in[l];
            end
            if (stage_ready[2]) begin
               x2_ff[l] <= x2_in[l];
            end
            if (stage_ready[3]) begin
               pb_ll_ff[l] <= pb_ll_in[l];
               pb_hl_ff[l] <= pb_hl_in[l];
               pb_lh_ff[l] <= pb_lh_in[l];
            end
            if (stage_ready[4]) begin
               fp4_ff[l] <= fp4_in[l];
            end
            if (stage_ready[5]) begin
               fp5_ff[l] <= fp4_ff[l];
            end
         end

         assign fp_out[l] = fp5_ff[l];
      end else begin : g_absent
         // lane not built: zero fingerprint, never kept
         assign kept_in[l] = 1'b0;
         assign fp_out[l]  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[PIPE_STAGES-1]) begin
         kept_ff <= kept_in;
      end
   end

   assign rsp_fingerprint_0 = fp_out[0];
   assign rsp_fingerprint_1 = fp_out[1];
   assign rsp_fingerprint_2 = fp_out[2];
   assign rsp_fingerprint_3 = fp_out[3];
   assign rsp_fingerprint_4 = fp_out[4];
   assign rsp_fingerprint_5 = fp_out[5];
   assign rsp_fingerprint_6 = fp_out[6];
   assign rsp_fingerprint_7 = fp_out[7];
   assign rsp_kept_mask     = kept_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted beat did not enter the first stage");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_ready) |-> !req_ready)
      else $error("input taken while the pipeline is full and stalled");

   a_stall_holds_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(kept_ff)))
      else $error("stalled result lost or changed");

   for (genvar l = 0; l < LANE_FIELDS; l++) begin : g_chk
      a_kept_under_thresh: assert property (@(posedge clock) disable iff (reset)
         (rsp_valid && rsp_kept_mask[l]) |-> (fp_out[l] <= thresh_ff))
         else $error("lane kept with fingerprint above threshold");
   end

endmodule

FILE: test/seeded_hash_threshold_filter_x8_test.sv
module seeded_hash_threshold_filter_x8_test;
   import shtf_pkg::*;

   localparam int unsigned LANE_COUNT      = 8;
   localparam int unsigned RANDOM_PHASES   = 7;
   localparam int unsigned BEATS_PER_PHASE = 200;
   localparam int unsigned REPORT_LIMIT    = 10;

   // Indexes the block must ignore
   localparam csr_index_type CSR_SPARE_2 = 2'd2;
   localparam csr_index_type CSR_SPARE_3 = 2'd3;

   // Lane i sits in element [i]; concatenations below list lane 7 first
   typedef logic [LANE_FIELDS-1:0][63:0] lane_words_type;

   typedef struct {
      lane_words_type value;
      lane_mask_type  lane_valid;
   } hash_beat_type;

   typedef struct {
      lane_words_type fingerprint;
      lane_mask_type  kept_mask;
   } filter_result_type;

   typedef struct {
      word_type          seed;
      word_type          threshold;
      hash_beat_type     beat;
      bit                typed;
      filter_result_type typed_result;
   } stim_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           csr_we = 1'b0;
   csr_index_type  csr_index = CSR_HASH_SEED;
   word_type       csr_wdata = '0;
   logic           req_valid = 1'b0;
   wire            req_ready;
   lane_words_type req_value = '0;
   lane_mask_type  req_lane_valid = '0;
   wire            rsp_valid;
   logic           rsp_ready = 1'b0;
   wire [LANE_FIELDS-1:0][63:0] rsp_fingerprint;
   wire [7:0]      rsp_kept_mask;

   // Shadow copies of the two registers, as the block should hold them
   word_type seed_shadow      = SEED_RESET;
   word_type threshold_shadow = THRESHOLD_RESET;

   filter_result_type pending_results[$];
   stim_row_type      directed_rows[$];
   int unsigned       mismatch_count = 0;
   bit                steady_phase = 1'b0;

   seeded_hash_threshold_filter_x8 #(
      .LANES(LANE_COUNT)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value_0       (req_value[0]),
      .req_value_1       (req_value[1]),
      .req_value_2       (req_value[2]),
      .req_value_3       (req_value[3]),
      .req_value_4       (req_value[4]),
      .req_value_5       (req_value[5]),
      .req_value_6       (req_value[6]),
      .req_value_7       (req_value[7]),
      .req_lane_valid    (req_lane_valid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fingerprint_0 (rsp_fingerprint[0]),
      .rsp_fingerprint_1 (rsp_fingerprint[1]),
      .rsp_fingerprint_2 (rsp_fingerprint[2]),
      .rsp_fingerprint_3 (rsp_fingerprint[3]),
      .rsp_fingerprint_4 (rsp_fingerprint[4]),
      .rsp_fingerprint_5 (rsp_fingerprint[5]),
      .rsp_fingerprint_6 (rsp_fingerprint[6]),
      .rsp_fingerprint_7 (rsp_fingerprint[7]),
      .rsp_kept_mask     (rsp_kept_mask)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Generous cap: several times the slowest legal run, which is every gap
   // and every stall at its longest
   initial begin
      #2000000;
      $display("[seeded_hash_threshold_filter_x8] ERROR");
      $finish;
   end

   // 64-bit finaliser: xor-shift, multiply, xor-shift, multiply, xor-shift.
   // Products are truncated to 64 bits by the assignment width.
   function automatic word_type mix_fingerprint(input word_type key);
      word_type h;
      h = key ^ (key >> MIX_SHIFT);
      h = h * MIX_MUL_A;
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL_B;
      h = h ^ (h >> MIX_SHIFT);
      return h;
   endfunction

   function automatic filter_result_type predict_filter(input hash_beat_type beat);
      filter_result_type r;
      r.fingerprint = '0;
      r.kept_mask   = '0;
      for (int unsigned lane = 0; lane < LANE_FIELDS; lane++) begin
         // lanes beyond the configured count read as zero and are never kept
         if (lane < LANE_COUNT) begin
            r.fingerprint[lane] = mix_fingerprint(beat.value[lane] ^ seed_shadow);
            if (beat.lane_valid[lane] && r.fingerprint[lane] <= threshold_shadow)
               r.kept_mask[lane] = 1'b1;
         end
      end
      return r;
   endfunction

   // Mostly short gaps, now and then a long one; none at all in steady phases
   function automatic int unsigned idle_gap();
      int unsigned pick;
      if (steady_phase)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 88)
         return $urandom_range(1, 3);
      else if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 48);
   endfunction

   // Directed rows with a typed result always expect all-zero fingerprints
   function automatic void add_row(input word_type seed, input word_type threshold,
                                   input lane_words_type value, input lane_mask_type lane_valid,
                                   input bit typed, input lane_mask_type typed_kept);
      stim_row_type row;
      row.seed                     = seed;
      row.threshold                = threshold;
      row.beat.value               = value;
      row.beat.lane_valid          = lane_valid;
      row.typed                    = typed;
      row.typed_result.fingerprint = '0;
      row.typed_result.kept_mask   = typed_kept;
      directed_rows.push_back(row);
   endfunction

   // Random content, biased towards zero, all ones, the seed itself (zero
   // fingerprint), a phase pivot (on the threshold in phase 3) and near misses
   function automatic hash_beat_type random_beat(input word_type pivot);
      hash_beat_type beat;
      for (int unsigned lane = 0; lane < LANE_FIELDS; lane++) begin
         case ($urandom_range(0, 9))
            0: beat.value[lane] = '0;
            1: beat.value[lane] = '1;
            2: beat.value[lane] = seed_shadow;
            3: beat.value[lane] = pivot;
            4: beat.value[lane] = 64'($urandom_range(0, 255));
            5: beat.value[lane] = seed_shadow ^ (64'h1 << $urandom_range(0, 63));
            default: beat.value[lane] = {$urandom, $urandom};
         endcase
      end
      case ($urandom_range(0, 9))
         0: beat.lane_valid = '0;
         1: beat.lane_valid = '1;
         2: beat.lane_valid = 8'h01 << $urandom_range(0, 7);
         default: beat.lane_valid = 8'($urandom_range(0, 255));
      endcase
      return beat;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_beat(input hash_beat_type beat, input bit typed,
                            input filter_result_type typed_result);
      int unsigned gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_value      <= beat.value;
      req_lane_valid <= beat.lane_valid;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (typed)
         pending_results.push_back(typed_result);
      else
         pending_results.push_back(predict_filter(beat));
      @(negedge clock);
   endtask

   // Drop valid and wait until every outstanding beat has come back
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (PIPE_STAGES + 2) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type index, input word_type data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      case (index)
         CSR_HASH_SEED:      seed_shadow = data;
         CSR_KEEP_THRESHOLD: threshold_shadow = data;
         default: ;
      endcase
   endtask

   // Writes to the spare indexes must leave both registers untouched
   task automatic load_settings(input word_type seed, input word_type threshold);
      settle_pipeline();
      csr_write(CSR_SPARE_2, {$urandom, $urandom});
      csr_write(CSR_HASH_SEED, seed);
      csr_write(CSR_SPARE_3, ~seed);
      csr_write(CSR_KEEP_THRESHOLD, threshold);
      csr_we <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input int lane,
                                  input word_type want, input word_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch: %s lane %0d expected %h got %h", what, lane, want, got);
   endtask

   // Receiver: open for a while, then stall for a random gap
   initial begin : rsp_stall
      int unsigned open_len;
      int unsigned stall_len;
      @(negedge clock);
      forever begin
         open_len  = $urandom_range(1, 12);
         stall_len = idle_gap();
         rsp_ready <= 1'b1;
         repeat (open_len) @(negedge clock);
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_len) @(negedge clock);
         end
      end
   end

   // Compare every accepted result beat with the oldest expectation
   always @(posedge clock) begin : rsp_check
      filter_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing outstanding", 0, '0, rsp_fingerprint[0]);
         end else begin
            want = pending_results.pop_front();
            for (int lane = 0; lane < LANE_FIELDS; lane++) begin
               if (rsp_fingerprint[lane] !== want.fingerprint[lane])
                  report_mismatch("fingerprint", lane, want.fingerprint[lane],
                                  rsp_fingerprint[lane]);
            end
            if (rsp_kept_mask !== want.kept_mask)
               report_mismatch("kept_mask", -1, 64'(want.kept_mask), 64'(rsp_kept_mask));
         end
      end
   end

   initial begin : stimulus
      stim_row_type  row;
      hash_beat_type beat;
      word_type      seed;
      word_type      threshold;
      word_type      pivot;
      word_type      odd_seed;

      odd_seed = 64'h0123_4567_89ab_cdef;

      // Reset values first: seed zero maps zero to zero, full threshold keeps
      // every valid lane
      add_row(SEED_RESET, THRESHOLD_RESET, '0, 8'hff, 1'b1, 8'hff);
      add_row(SEED_RESET, THRESHOLD_RESET, '0, 8'h00, 1'b1, 8'h00);
      add_row(SEED_RESET, THRESHOLD_RESET, '1, 8'hff, 1'b0, '0);
      add_row(SEED_RESET, THRESHOLD_RESET, '1, 8'h00, 1'b0, '0);
      add_row(SEED_RESET, THRESHOLD_RESET,
              {64'd7, 64'd6, 64'd5, 64'd4, 64'd3, 64'd2, 64'd1, 64'd0}, 8'h55, 1'b0, '0);
      add_row(SEED_RESET, THRESHOLD_RESET, {8{64'h8000_0000_0000_0000}}, 8'h01, 1'b0, '0);
      add_row(SEED_RESET, THRESHOLD_RESET,
              {4{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa}}, 8'h80, 1'b0, '0);
      add_row(SEED_RESET, THRESHOLD_RESET,
              {64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000,
               64'h1, 64'hdead_beef_cafe_f00d, 64'h0123_4567_89ab_cdef,
               64'hfedc_ba98_7654_3210, 64'h5555_5555_5555_5555}, 8'ha5, 1'b0, '0);
      // All-ones seed cancels all-ones values; zero threshold keeps exact zeros
      add_row('1, '0, '1, 8'hff, 1'b1, 8'hff);
      add_row('1, '0, '1, 8'h3c, 1'b1, 8'h3c);
      add_row('1, '0, '0, 8'hff, 1'b0, '0);
      add_row('1, '0, {{4{64'h0}}, {4{64'hffff_ffff_ffff_ffff}}}, 8'hff, 1'b0, '0);
      add_row(odd_seed, '0, {8{odd_seed}}, 8'h0f, 1'b1, 8'h0f);
      add_row(odd_seed, '0, {8{odd_seed ^ 64'h1}}, 8'hff, 1'b0, '0);
      add_row(odd_seed, 64'h8000_0000_0000_0000,
              {64'h1111, 64'h2222, 64'h3333, 64'h4444, 64'h5555, 64'h6666, 64'h7777,
               64'h8888}, 8'hff, 1'b0, '0);
      add_row(odd_seed, 64'h8000_0000_0000_0000, '0, 8'haa, 1'b0, '0);
      add_row(SEED_RESET, 64'h7fff_ffff_ffff_ffff, '1, 8'hff, 1'b0, '0);
      add_row(SEED_RESET, 64'h7fff_ffff_ffff_ffff, '0, 8'hff, 1'b1, 8'hff);
      add_row(SEED_RESET, THRESHOLD_RESET, '0, 8'h81, 1'b1, 8'h81);

      // Hold reset, then release it at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.seed != seed_shadow || row.threshold != threshold_shadow)
            load_settings(row.seed, row.threshold);
         send_beat(row.beat, row.typed, row.typed_result);
      end

      // Random phases, each with its own register setting
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         pivot = {$urandom, $urandom};
         seed  = {$urandom, $urandom};
         case (phase)
            0: threshold = THRESHOLD_RESET;
            1: begin
               seed      = '0;
               threshold = '0;
            end
            2: begin
               seed      = '1;
               threshold = 64'h8000_0000_0000_0000;
            end
            // pivot lanes land exactly on the threshold
            3: threshold = mix_fingerprint(pivot ^ seed);
            5: begin
               seed      = '1;
               threshold = '1;
            end
            default: threshold = {$urandom, $urandom};
         endcase
         load_settings(seed, threshold);
         steady_phase = ($urandom_range(0, 3) == 0);
         for (int unsigned n = 0; n < BEATS_PER_PHASE; n++) begin
            beat = random_beat(pivot);
            send_beat(beat, 1'b0, '{default: '0});
         end
      end

      // Drain, then keep watching for anything stray
      steady_phase = 1'b0;
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (PIPE_STAGES + 4) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("[seeded_hash_threshold_filter_x8] OK");
      else
         $display("[seeded_hash_threshold_filter_x8] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/shtf_pkg.sv
rtl/seeded_hash_threshold_filter_x8.sv
test/seeded_hash_threshold_filter_x8_test.sv
